### sv/chc_pkg.sv
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types, constants and functions for the census Hamming cost engine.
// ----------------------------------------------------------------------------
`default_nettype none

package chc_pkg;

    // Descriptor and field widths
    localparam int DESC_W      = 24;
    localparam int COL_W       = 12;
    localparam int COST_W      = 5;
    localparam int DISP_W      = 6;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    // Right descriptor history
    localparam int HIST_DEPTH  = 128;
    localparam int HIST_AW     = 7;

    // Cost when the right column lies outside the image
    localparam logic [COST_W-1:0] OUTSIDE_COST = 5'd24;

    // Defaults for the top level parameters
    localparam int DEF_MAX_DISPARITIES   = 64;
    localparam int DEF_MAX_MIN_DISPARITY = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISPARITY   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DISPARITIES = 8'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_MIN_DISPARITY   = 7'd0;
    localparam logic [CFG_W-1:0] RST_NUM_DISPARITIES = 7'd64;

    typedef struct packed {
        logic [DESC_W-1:0] left_code;
        logic [DESC_W-1:0] right_code;
        logic [COL_W-1:0]  pixel_column;
    } pixel_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [DISP_W-1:0] disparity_index;
        logic              last_of_pixel;
    } cost_t;

    // Number of ones in a descriptor
    function automatic logic [COST_W-1:0] bit_count(input logic [DESC_W-1:0] v);
        logic [COST_W-1:0] n;
        n = '0;
        for (int i = 0; i < DESC_W; i++)
        begin
            n = n + COST_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### sv/census_hamming_cost_volume_top.sv
// ----------------------------------------------------------------------------
// census_hamming_cost_volume_top
// Stereo matching cost engine: Hamming distance between the left descriptor
// and past right descriptors, one cost per disparity level.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | direction | payload
//  --------+-------------------------------+-----------+------------------
//  pixel   | in_valid, in_stall, in_data   | in        | pixel_t
//  cost    | out_valid, out_stall, out_data| out       | cost_t
//  config  | cfg_valid, cfg_ready          | in        | cfg_index, cfg_data
//
// A new pixel waits while the previous one has costs to issue or in the read
// stage; a pixel with no levels does not hold the input. Costs leave at one
// per cycle unless stalled, set by the single read port of the history RAM.
// Reset clears the write pointer, the registers and all control state; the
// history memory is not cleared. A stall on the cost side freezes the read
// stage, which re-reads its entry until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module census_hamming_cost_volume_top #(
    parameter int MAX_DISPARITIES   = chc_pkg::DEF_MAX_DISPARITIES,
    parameter int MAX_MIN_DISPARITY = chc_pkg::DEF_MAX_MIN_DISPARITY
) (
    input  wire                               clk,
    input  wire                               rst_n,

    input  wire                               in_valid,
    output logic                              in_stall,
    input  chc_pkg::pixel_t                   in_data,

    output logic                              out_valid,
    input  wire                               out_stall,
    output chc_pkg::cost_t                    out_data,

    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [chc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [chc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import chc_pkg::*;

    // Offset width: at least the history address plus one, to see >= depth
    localparam int OFF_RAW = $clog2(MAX_MIN_DISPARITY + MAX_DISPARITIES + 1);
    localparam int OFF_W   = (OFF_RAW > HIST_AW + 1) ? OFF_RAW : HIST_AW + 1;
    localparam int CMP_W   = (OFF_W > COL_W) ? OFF_W : COL_W;

    // Configuration registers
    logic [CFG_W-1:0] min_disp_reg;
    logic [CFG_W-1:0] num_disp_reg;
    logic [CFG_W-1:0] min_sat;
    logic [CFG_W-1:0] num_sat;

    // Per-pixel context
    logic [DESC_W-1:0]  left_reg;
    logic [COL_W-1:0]   col_reg;
    logic [CFG_W-1:0]   mind_reg;
    logic [CFG_W-1:0]   nd_reg;
    logic [HIST_AW-1:0] base_wp_reg;
    logic [HIST_AW-1:0] wp_reg;

    // Issue counter and read stage
    logic               issuing_reg;
    logic [CFG_W-1:0]   issue_cnt_reg;
    logic               s1_valid_reg;
    logic [DISP_W-1:0]  s1_disp_reg;
    logic               s1_outside_reg;
    logic               s1_last_reg;
    logic [HIST_AW-1:0] s1_slot_reg;

    // Output register
    logic               out_valid_reg;
    cost_t              out_data_reg;

    // History memory
    logic [DESC_W-1:0]  hist_mem [HIST_DEPTH];
    logic [DESC_W-1:0]  hist_q_reg;

    logic               accept;
    logic               advance;
    logic [OFF_W-1:0]   offset;
    logic [HIST_AW-1:0] issue_slot;
    logic [HIST_AW-1:0] rd_addr;
    logic               issue_outside;
    logic               issue_last;
    logic [COST_W-1:0]  s1_cost;

    // Saturate the configured values
    always_comb
    begin
        min_sat = (int'(min_disp_reg) > MAX_MIN_DISPARITY) ?
                  CFG_W'(MAX_MIN_DISPARITY) : min_disp_reg;
        num_sat = (int'(num_disp_reg) > MAX_DISPARITIES) ?
                  CFG_W'(MAX_DISPARITIES) : num_disp_reg;
    end

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = issuing_reg | s1_valid_reg;
    assign accept    = in_valid & ~in_stall;
    assign advance   = ~out_valid_reg | ~out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Candidate for the current issue count
    always_comb
    begin
        offset        = OFF_W'(mind_reg) + OFF_W'(issue_cnt_reg);
        issue_slot    = base_wp_reg - offset[HIST_AW-1:0];
        issue_outside = (CMP_W'(offset) > CMP_W'(col_reg)) ||
                        (offset >= OFF_W'(HIST_DEPTH));
        issue_last    = (issue_cnt_reg + 1'b1) == nd_reg;
        rd_addr       = advance ? issue_slot : s1_slot_reg;
    end

    // Cost from the read stage
    assign s1_cost = s1_outside_reg ? OUTSIDE_COST : bit_count(left_reg ^ hist_q_reg);

    // History memory: write on pixel transfer, registered read every cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[wp_reg] <= in_data.right_code;
        end
        hist_q_reg <= hist_mem[rd_addr];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_disp_reg <= RST_MIN_DISPARITY;
            num_disp_reg <= RST_NUM_DISPARITIES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MIN_DISPARITY)
            begin
                min_disp_reg <= cfg_data[CFG_W-1:0];
            end
            else if (cfg_index == REG_NUM_DISPARITIES)
            begin
                num_disp_reg <= cfg_data[CFG_W-1:0];
            end
        end
    end

    // Pixel context, latched on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg    <= in_data.left_code;
            col_reg     <= in_data.pixel_column;
            mind_reg    <= min_sat;
            nd_reg      <= num_sat;
            base_wp_reg <= wp_reg;
        end
    end

    // Control: write pointer, issue counter, read stage valid, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            issuing_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg        <= wp_reg + 1'b1;
                issuing_reg   <= (num_sat != '0);
                issue_cnt_reg <= '0;
            end
            else if (advance && issuing_reg)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                if (issue_last)
                begin
                    issuing_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                s1_valid_reg  <= issuing_reg;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Read stage and output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_disp_reg    <= issue_cnt_reg[DISP_W-1:0];
            s1_outside_reg <= issue_outside;
            s1_last_reg    <= issue_last;
            s1_slot_reg    <= issue_slot;

            out_data_reg.cost            <= s1_cost;
            out_data_reg.disparity_index <= s1_disp_reg;
            out_data_reg.last_of_pixel   <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire

### bench/tb_census_hamming_cost_volume_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_census_hamming_cost_volume_top
// Self-checking bench for the census Hamming cost engine. Pixels are streamed
// in rows with random descriptors, and the registers are changed between
// bursts. A cost-volume predictor keeps its own right-descriptor history and
// queues the expected cost of each disparity level, and every cost transfer
// is checked field by field against the oldest queued entry.
// ----------------------------------------------------------------------------

module tb_census_hamming_cost_volume_top;

    import chc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 8;
    localparam int TAIL_WAIT   = 80;
    localparam int HOLD_LEN    = 400;
    localparam int MAX_REPORTS = 10;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    // ------------------------------------------------------------------------
    // Cost-volume predictor and queue of expected costs
    // ------------------------------------------------------------------------
    class disparity_cost_board;
        logic [DESC_W-1:0]  right_seen [HIST_DEPTH];
        logic [HIST_AW-1:0] wr_slot  = '0;
        logic [CFG_W-1:0]   min_disp = RST_MIN_DISPARITY;
        logic [CFG_W-1:0]   num_disp = RST_NUM_DISPARITIES;
        cost_t              expected_costs [$];
        int                 errors = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_MIN_DISPARITY)
            begin
                min_disp = val[CFG_W-1:0];
            end
            else if (idx == REG_NUM_DISPARITIES)
            begin
                num_disp = val[CFG_W-1:0];
            end
        endfunction

        // Queue one cost per disparity level for an accepted pixel
        function void note_pixel(pixel_t px);
            int                 first_off;
            int                 levels;
            int                 off;
            int                 col;
            logic [HIST_AW-1:0] slot;
            cost_t              c;
            first_off = (min_disp > DEF_MAX_MIN_DISPARITY) ? DEF_MAX_MIN_DISPARITY
                                                           : int'(min_disp);
            levels    = (num_disp > DEF_MAX_DISPARITIES) ? DEF_MAX_DISPARITIES
                                                         : int'(num_disp);
            col       = int'(px.pixel_column);
            // current right descriptor goes in first, so offset zero sees it
            right_seen[wr_slot] = px.right_code;
            for (int d = 0; d < levels; d++)
            begin
                off = first_off + d;
                if (off > col || off >= HIST_DEPTH)
                begin
                    c.cost = OUTSIDE_COST;
                end
                else
                begin
                    slot   = wr_slot - HIST_AW'(off);
                    c.cost = COST_W'($countones(px.left_code ^ right_seen[slot]));
                end
                c.disparity_index = DISP_W'(d);
                c.last_of_pixel   = (d + 1 == levels);
                expected_costs.push_back(c);
            end
            wr_slot = wr_slot + 1'b1;
        endfunction

        function void report(string msg);
            if (errors < MAX_REPORTS)
            begin
                $display("%s", msg);
            end
            errors++;
        endfunction

        function void check_cost(cost_t got);
            cost_t want;
            if (expected_costs.size() == 0)
            begin
                report($sformatf("unexpected cost: cost %0d level %0d last %0b",
                                 got.cost, got.disparity_index, got.last_of_pixel));
                return;
            end
            want = expected_costs.pop_front();
            if (got.cost !== want.cost || got.disparity_index !== want.disparity_index
                || got.last_of_pixel !== want.last_of_pixel)
            begin
                report($sformatf({"cost mismatch: expected cost %0d level %0d last %0b,",
                                  " got cost %0d level %0d last %0b"},
                                 want.cost, want.disparity_index, want.last_of_pixel,
                                 got.cost, got.disparity_index, got.last_of_pixel));
            end
        endfunction

        function int pending();
            return expected_costs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    pixel_t                in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    cost_t                 out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    census_hamming_cost_volume_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    disparity_cost_board board;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    bit                  hold_req = 1'b0;
    int                  cycles = 0;

    // Row generator state
    int                  pixels_made = 0;
    int                  next_col = 0;
    logic [DESC_W-1:0]   recent_rights [$];

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Cost side: random stalls, one long hold-off on request, checking
    // ------------------------------------------------------------------------
    initial
    begin : cost_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                board.check_cost(out_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel generation
    // ------------------------------------------------------------------------
    // Columns stay within the written history until the history has wrapped once
    function automatic pixel_t make_pixel(logic [DESC_W-1:0] l, logic [DESC_W-1:0] r,
                                          int col);
        pixel_t px;
        if (pixels_made < HIST_DEPTH - 1 && col > pixels_made)
        begin
            col = pixels_made;
        end
        px.left_code    = l;
        px.right_code   = r;
        px.pixel_column = COL_W'(col);
        next_col        = (col + 1) % (1 << COL_W);
        pixels_made++;
        recent_rights.push_front(r);
        if (recent_rights.size() > DEF_MAX_DISPARITIES)
        begin
            void'(recent_rights.pop_back());
        end
        return px;
    endfunction

    function automatic pixel_t random_pixel();
        logic [DESC_W-1:0] l;
        logic [DESC_W-1:0] r;
        logic [DESC_W-1:0] flips;
        int                roll;
        int                col;
        roll = $urandom_range(9);
        r = (roll == 0) ? '0 : (roll == 1) ? '1 : DESC_W'($urandom());
        // left often near a recent right descriptor so that low costs show up
        flips = ($urandom_range(2) == 0) ? '0 :
                (DESC_W'(1) << $urandom_range(DESC_W - 1)) |
                (DESC_W'(1) << $urandom_range(DESC_W - 1));
        roll = $urandom_range(9);
        if (roll < 4 && recent_rights.size() > 0)
        begin
            l = recent_rights[$urandom_range(recent_rights.size() - 1)] ^ flips;
        end
        else if (roll == 4)
        begin
            l = ($urandom_range(1) == 0) ? '0 : '1;
        end
        else
        begin
            l = DESC_W'($urandom());
        end
        // mostly raster order, sometimes new rows, skips, repeats or noise
        roll = $urandom_range(99);
        if (roll < 80)
        begin
            col = next_col;
        end
        else if (roll < 87)
        begin
            col = 0;
        end
        else if (roll < 93)
        begin
            col = next_col + $urandom_range(1, 6);
        end
        else if (roll < 97)
        begin
            col = (next_col > 0) ? next_col - 1 : 0;
        end
        else
        begin
            col = ($urandom_range(1) == 0) ? (1 << COL_W) - 1
                                           : $urandom_range((1 << COL_W) - 1);
        end
        return make_pixel(l, r, col % (1 << COL_W));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Entered and left at a falling edge; valid stays high into the next call
    task automatic send_pixel(pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pixel(px);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_disparities(logic [CFG_DATA_W-1:0] first_off,
                                   logic [CFG_DATA_W-1:0] levels);
        write_reg(REG_MIN_DISPARITY, first_off);
        write_reg(REG_NUM_DISPARITIES, levels);
    endtask

    // Wait for every queued cost, then DRAIN_WAIT more for pixels with no costs
    task automatic wait_idle();
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic run_pixels(int count);
        for (int i = 0; i < count; i++)
        begin
            send_pixel(random_pixel());
        end
        in_valid <= 1'b0;
        wait_idle();
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_reg(int lo, int hi);
        return {1'($urandom_range(1)), CFG_W'($urandom_range(hi, lo))};
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [DESC_W-1:0]     l;
        logic [DESC_W-1:0]     r;
        logic [CFG_DATA_W-1:0] first_off;
        logic [CFG_DATA_W-1:0] levels;
        int                    roll;
        board = new;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 88;
        repeat (3) @(negedge clk);

        // Reset settings: descriptor extremes, then a repeated column
        for (int i = 0; i < 12; i++)
        begin
            case (i)
                0:       begin l = '0;          r = '0;          end
                1:       begin l = '1;          r = '0;          end
                2:       begin l = '0;          r = '1;          end
                3:       begin l = '1;          r = '1;          end
                4:       begin l = 24'hAAAAAA;  r = 24'h555555;  end
                5:       begin l = 24'h000001;  r = 24'h800000;  end
                default: begin l = DESC_W'($urandom()); r = DESC_W'($urandom()); end
            endcase
            send_pixel(make_pixel(l, r, (i < 7) ? i : i - 1));
        end
        in_valid <= 1'b0;
        wait_idle();

        // Registers at or above their maximum, bit 7 of the data set in the first pair
        set_disparities(8'hFF, 8'hC0);
        run_pixels(3);
        set_disparities(8'h00, 8'h7F);
        run_pixels(3);
        // Zero levels: history still advances, no costs
        set_disparities(8'h05, 8'h00);
        run_pixels(3);
        // Writes to unused indexes must leave the registers alone
        set_disparities(8'h02, 8'h01);
        write_reg(REG_UNUSED_LOW, 8'hFF);
        write_reg(REG_UNUSED_TOP, 8'h00);
        run_pixels(3);

        // Random bursts, each with its own register settings
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph / 4)
                0:       begin send_idle_pct = 23; recv_idle_pct = 88; end
                1:       begin send_idle_pct = 88; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (ph)
                0:       set_disparities(8'd64, 8'd64);
                1:       set_disparities(8'd0, 8'd1);
                5:       set_disparities(8'd0, 8'd64);
                8:       set_disparities(8'd0, 8'd64);
                default:
                begin
                    first_off = ($urandom_range(3) == 0) ? random_reg(0, 127)
                                                         : random_reg(0, 16);
                    roll = $urandom_range(11);
                    levels = (roll == 0) ? random_reg(0, 0) :
                             (roll == 1) ? random_reg(65, 127) : random_reg(1, 64);
                    set_disparities(first_off, levels);
                end
            endcase
            // long hold-off on the cost side so that the input backs up
            if (ph == 8)
            begin
                hold_req = 1'b1;
            end
            run_pixels(34);
        end

        repeat (TAIL_WAIT) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
